>>> rtl/relay_schedule_controller_macros.svh
// ----------------------------------------------------------------------------
// relay_schedule_controller_macros
// Assertion macros for the relay schedule controller; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RELAY_SCHEDULE_CONTROLLER_MACROS_SVH
`define RELAY_SCHEDULE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared widths, register indexes, codes and control structs.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int unsigned TIME_W     = 27;
    localparam int unsigned PERIOD_W   = TIME_W + 1;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = TIME_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_TIME   = 2'd2,
        MODE_PWM    = 2'd3
    } t_mode;

    // How the working level register is updated
    typedef enum logic [2:0] {
        LV_HOLD   = 3'd0,
        LV_ZERO   = 3'd1,
        LV_MANUAL = 3'd2,
        LV_ENTRY  = 3'd3,
        LV_PWM    = 3'd4
    } t_level_op;

    typedef struct packed {
        logic      load_we;
        logic      tick_start;
        logic      rd_wrap;
        logic      rd_scan;
        logic      mod_start;
        t_level_op level_op;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  count_zero;
        logic  pwm_off;
        logic  scan_hit;
        logic  scan_last;
        logic  mod_done;
        logic  out_free;
    } t_status;

endpackage

>>> rtl/rsc_mod.sv
// ----------------------------------------------------------------------------
// rsc_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rsc_mod
    import rsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TIME_W-1:0]   i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_rem
);

    localparam int unsigned STEP_W = $clog2(TIME_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [TIME_W-1:0]   r_dvd;
    logic [PERIOD_W-1:0] r_div;
    logic [PERIOD_W-1:0] r_rem;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                fits;

    assign trial = {r_rem, r_dvd[TIME_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/rsc_dpath.sv
// ----------------------------------------------------------------------------
// rsc_dpath
// Configuration registers, timeline memory, scan pointer, level and output.
// ----------------------------------------------------------------------------
module rsc_dpath
    import rsc_pkg::*;
#(
    parameter int unsigned NUM_ENTRIES = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [INDEX_W-1:0]    i_entry_index,
    input  logic [TIME_W-1:0]     i_entry_time_ms,
    input  logic                  i_entry_level,
    input  logic                  i_stall,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_valid,
    output logic                  o_relay_level,
    output logic                  o_heartbeat_led
);

    localparam int unsigned ADDR_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int unsigned PTR_W  = $clog2(NUM_ENTRIES + 1);
    localparam int unsigned CMP_W  = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    // Configuration
    t_mode               r_mode;
    logic [TIME_W-1:0]   r_on;
    logic [TIME_W-1:0]   r_off;
    logic                r_manual;
    logic [COUNT_W-1:0]  r_count;

    // Timeline memory: {time, level}
    logic [TIME_W:0]     mem [NUM_ENTRIES];
    logic [TIME_W:0]     r_rd;

    logic [TIME_W-1:0]   r_now;
    logic [PTR_W-1:0]    r_k;
    logic                r_level;
    logic                r_out_valid;
    logic                r_out_level;
    logic                r_hb;

    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    num_ext;
    logic [CMP_W-1:0]    count_clamp;
    logic [PTR_W-1:0]    cnt_use;
    logic [PTR_W-1:0]    last_ptr;
    logic [PTR_W-1:0]    rd_ptr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_ok;
    logic [TIME_W-1:0]   rd_time;
    logic                rd_level;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] mod_rem;
    logic                mod_done;
    logic                pwm_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_on     <= '0;
            r_off    <= '0;
            r_manual <= 1'b0;
            r_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[MODE_W-1:0]);
                CFG_ON:     r_on     <= i_cfg_data[TIME_W-1:0];
                CFG_OFF:    r_off    <= i_cfg_data[TIME_W-1:0];
                CFG_MANUAL: r_manual <= i_cfg_data[0];
                CFG_COUNT:  r_count  <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the entry count to the memory depth
    assign count_ext   = CMP_W'(r_count);
    assign num_ext     = CMP_W'(NUM_ENTRIES);
    assign count_clamp = (count_ext > num_ext) ? num_ext : count_ext;
    assign cnt_use     = PTR_W'(count_clamp);
    assign last_ptr    = cnt_use - PTR_W'(1);
    assign rd_ptr      = i_cmd.rd_wrap ? last_ptr : r_k;
    assign rd_addr     = rd_ptr[ADDR_W-1:0];

    assign wr_ok   = (32'(i_entry_index) < NUM_ENTRIES);
    assign wr_addr = ADDR_W'(i_entry_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && wr_ok) begin
            mem[wr_addr] <= {i_entry_time_ms, i_entry_level};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_wrap || i_cmd.rd_scan) begin
            r_rd <= mem[rd_addr];
        end
    end

    assign rd_time  = r_rd[TIME_W:1];
    assign rd_level = r_rd[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.tick_start) begin
            r_k <= '0;
        end else if (i_cmd.rd_scan) begin
            r_k <= r_k + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_now <= i_now_ms;
        end
    end

    assign period = {1'b0, r_on} + {1'b0, r_off};

    rsc_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (i_now_ms),
        .i_divisor  (period),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign pwm_level = (mod_rem <= {1'b0, r_on});

    always_ff @(posedge i_clk) begin
        case (i_cmd.level_op)
            LV_ZERO:   r_level <= 1'b0;
            LV_MANUAL: r_level <= r_manual;
            LV_ENTRY:  r_level <= rd_level;
            LV_PWM:    r_level <= pwm_level;
            default:   r_level <= r_level;
        endcase
    end

    // Output register; the heartbeat toggles with every result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hb        <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
            r_hb        <= ~r_hb;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_level <= r_level;
        end
    end

    assign o_status.mode       = r_mode;
    assign o_status.count_zero = (cnt_use == '0);
    assign o_status.pwm_off    = (r_on == '0) || (r_off == '0);
    assign o_status.scan_hit   = (r_now > rd_time);
    assign o_status.scan_last  = (r_k == cnt_use);
    assign o_status.mod_done   = mod_done;
    assign o_status.out_free   = !r_out_valid || !i_stall;

    assign o_valid         = r_out_valid;
    assign o_relay_level   = r_out_level;
    assign o_heartbeat_led = r_hb;

endmodule

>>> rtl/rsc_ctrl.sv
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer: accepts transactions and steps the datapath through a tick.
// ----------------------------------------------------------------------------
`include "relay_schedule_controller_macros.svh"

module rsc_ctrl
    import rsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_kind,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WRAP = 5'b00010,
        S_SCAN = 5'b00100,
        S_MOD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.level_op = LV_HOLD;
        case (r_state)
            S_IDLE: begin
                if (accept && i_kind) begin
                    o_cmd.load_we = 1'b1;
                end else if (accept) begin
                    o_cmd.tick_start = 1'b1;
                    case (i_status.mode)
                        MODE_MANUAL: begin
                            o_cmd.level_op = LV_MANUAL;
                            n_state        = S_DONE;
                        end
                        MODE_TIME: begin
                            if (i_status.count_zero) begin
                                o_cmd.level_op = LV_ZERO;
                                n_state        = S_DONE;
                            end else begin
                                o_cmd.rd_wrap = 1'b1;
                                n_state       = S_WRAP;
                            end
                        end
                        MODE_PWM: begin
                            if (i_status.pwm_off) begin
                                o_cmd.level_op = LV_ZERO;
                                n_state        = S_DONE;
                            end else begin
                                o_cmd.mod_start = 1'b1;
                                n_state         = S_MOD;
                            end
                        end
                        default: begin
                            o_cmd.level_op = LV_ZERO;
                            n_state        = S_DONE;
                        end
                    endcase
                end
            end
            S_WRAP: begin
                // Last entry's level is the fallback; start the scan at slot 0
                o_cmd.level_op = LV_ENTRY;
                o_cmd.rd_scan  = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_hit) begin
                    o_cmd.level_op = LV_ENTRY;
                    if (i_status.scan_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.rd_scan = 1'b1;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                if (i_status.mod_done) begin
                    o_cmd.level_op = LV_PWM;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RSC_ASSERT_NEXT(a_load_stays_idle, i_clk, i_rst_n, accept && i_kind, r_state == S_IDLE, "load transaction left idle")
    `RSC_ASSERT_NEXT(a_tick_leaves_idle, i_clk, i_rst_n, accept && !i_kind, r_state != S_IDLE, "tick transaction did not start work")
    `RSC_ASSERT_IMPL(a_mod_done_in_mod, i_clk, i_rst_n, i_status.mod_done, r_state == S_MOD, "remainder finished outside its wait state")

endmodule

>>> rtl/relay_schedule_controller.sv
// ----------------------------------------------------------------------------
// relay_schedule_controller
// One relay channel: timeline schedule, pwm, manual and off modes, heartbeat.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------------------
//  input     i_valid / o_stall    i_kind, i_now_ms, i_entry_index,
//                                 i_entry_time_ms, i_entry_level
//  output    o_valid / i_stall    o_relay_level, o_heartbeat_led
//  config    i_cfg_we             i_cfg_index, i_cfg_data
//
//  A load transaction produces no result.
//  A tick's result waits only on the done state in off and manual modes; in
//  time mode it also waits on one timeline memory read per slot scanned, and
//  in pwm mode on the remainder unit, which retires one dividend bit per
//  cycle, 27 bits.
//  Reset is synchronous and active low; the timeline memory is not cleared.
//  The input is stalled while a tick is in progress, or while a finished
//  result waits for a full output register to drain.
//
module relay_schedule_controller
    import rsc_pkg::*;
#(
    parameter int unsigned NUM_ENTRIES = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [INDEX_W-1:0]    i_entry_index,
    input  logic [TIME_W-1:0]     i_entry_time_ms,
    input  logic                  i_entry_level,

    // Output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_relay_level,
    output logic                  o_heartbeat_led,

    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Sequencer: accept transactions, walk the timeline, wait on the remainder
    rsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // Datapath: registers, timeline memory, remainder unit, output register
    rsc_dpath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_now_ms        (i_now_ms),
        .i_entry_index   (i_entry_index),
        .i_entry_time_ms (i_entry_time_ms),
        .i_entry_level   (i_entry_level),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_relay_level   (o_relay_level),
        .o_heartbeat_led (o_heartbeat_led)
    );

endmodule

>>> tb/relay_schedule_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_schedule_tb_pkg
// Transaction codes and result record shared by the testbench modules.
// ----------------------------------------------------------------------------
package relay_schedule_tb_pkg;

    // Input transaction kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic relay_level;
        logic heartbeat_led;
    } t_relay_result;

endpackage

>>> tb/relay_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_schedule_checker
// Watches the input, output and register ports of the relay channel, keeps
// its own copy of timeline, registers and heartbeat, predicts the level of
// every tick and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module relay_schedule_checker
    import rsc_pkg::*;
    import relay_schedule_tb_pkg::*;
#(
    parameter int unsigned NUM_ENTRIES = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_kind,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [INDEX_W-1:0]    i_entry_index,
    input  logic [TIME_W-1:0]     i_entry_time_ms,
    input  logic                  i_entry_level,

    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_relay_level,
    input  logic                  i_heartbeat_led,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    output int                    o_fail_count,
    output int                    o_pending
);

    t_mode               mode_q;
    logic [TIME_W-1:0]   on_ms_q;
    logic [TIME_W-1:0]   off_ms_q;
    logic                manual_q;
    logic [COUNT_W-1:0]  count_q;
    logic                heartbeat_q;

    logic [TIME_W-1:0]   switch_time_q  [NUM_ENTRIES];
    logic                switch_level_q [NUM_ENTRIES];

    t_relay_result       expected_levels_q [$];
    int                  fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("[%0t] relay check: %s", $time, what);
    endtask

    // Level of the latest switch strictly before now, wrapping to the last one.
    function automatic logic timeline_level(input logic [TIME_W-1:0] now);
        int unsigned used;
        int unsigned k;
        logic        level;
        used = (count_q > NUM_ENTRIES) ? NUM_ENTRIES : count_q;
        if (used == 0) begin
            return 1'b0;
        end
        level = switch_level_q[used-1];
        for (k = 0; k < used; k++) begin
            if (now > switch_time_q[k]) begin
                level = switch_level_q[k];
            end else begin
                break;
            end
        end
        return level;
    endfunction

    function automatic logic pwm_level(input logic [TIME_W-1:0] now);
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] phase;
        if (on_ms_q == '0 || off_ms_q == '0) begin
            return 1'b0;
        end
        period = PERIOD_W'(on_ms_q) + PERIOD_W'(off_ms_q);
        phase  = PERIOD_W'(now) % period;
        return phase <= PERIOD_W'(on_ms_q);
    endfunction

    function automatic logic relay_level_at(input logic [TIME_W-1:0] now);
        case (mode_q)
            MODE_MANUAL: return manual_q;
            MODE_TIME:   return timeline_level(now);
            MODE_PWM:    return pwm_level(now);
            default:     return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin : track
        t_relay_result want;
        if (!i_rst_n) begin
            mode_q      = MODE_OFF;
            on_ms_q     = '0;
            off_ms_q    = '0;
            manual_q    = 1'b0;
            count_q     = '0;
            heartbeat_q = 1'b0;
            expected_levels_q.delete();
            o_pending  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:   mode_q   = t_mode'(i_cfg_data[MODE_W-1:0]);
                    CFG_ON:     on_ms_q  = i_cfg_data[TIME_W-1:0];
                    CFG_OFF:    off_ms_q = i_cfg_data[TIME_W-1:0];
                    CFG_MANUAL: manual_q = i_cfg_data[0];
                    CFG_COUNT:  count_q  = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            // Retire the oldest expectation on each output transaction.
            if (i_out_valid && !i_out_stall) begin
                if (expected_levels_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result level=%0b led=%0b",
                                              i_relay_level, i_heartbeat_led));
                end else begin
                    want = expected_levels_q.pop_front();
                    if (i_relay_level !== want.relay_level) begin
                        report_mismatch($sformatf("relay_level got %0b want %0b",
                                                  i_relay_level, want.relay_level));
                    end
                    if (i_heartbeat_led !== want.heartbeat_led) begin
                        report_mismatch($sformatf("heartbeat_led got %0b want %0b",
                                                  i_heartbeat_led, want.heartbeat_led));
                    end
                end
            end

            // Loads update the timeline; ticks queue one expected result.
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_LOAD) begin
                    if (i_entry_index < NUM_ENTRIES) begin
                        switch_time_q[i_entry_index]  = i_entry_time_ms;
                        switch_level_q[i_entry_index] = i_entry_level;
                    end
                end else begin
                    heartbeat_q        = ~heartbeat_q;
                    want.relay_level   = relay_level_at(i_now_ms);
                    want.heartbeat_led = heartbeat_q;
                    expected_levels_q.push_back(want);
                end
            end
            o_pending <= expected_levels_q.size();
        end
    end

endmodule

>>> tb/tb_relay_schedule_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relay_schedule_controller
// Drives ticks and timeline loads into one relay channel under changing
// register settings, with random idle and back-pressure bursts; a checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_relay_schedule_controller;
    import rsc_pkg::*;
    import relay_schedule_tb_pkg::*;

    localparam int unsigned NUM_ENTRIES    = 16;
    localparam int unsigned ITEM_TARGET    = 1850;
    localparam int unsigned QUIET_FROM     = 1650;
    // Longest tick is the pwm remainder; leave margin.
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DAY_MS         = 86_400_000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;

    logic                  i_valid;
    logic                  o_stall;
    logic                  i_kind;
    logic [TIME_W-1:0]     i_now_ms;
    logic [INDEX_W-1:0]    i_entry_index;
    logic [TIME_W-1:0]     i_entry_time_ms;
    logic                  i_entry_level;

    logic                  o_valid;
    logic                  i_stall;
    logic                  o_relay_level;
    logic                  o_heartbeat_led;

    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int                    fail_count;
    int                    pending;

    // Stimulus shaping state: idle switches per phase, and the switch times
    // last loaded so ticks can land right on them.
    logic                  in_idle_en  = 1'b0;
    logic                  out_idle_en = 1'b0;
    logic                  quiet       = 1'b0;
    int unsigned           items_sent  = 0;
    logic [TIME_W-1:0]     slot_time [NUM_ENTRIES];

    always #10 i_clk = ~i_clk;

    relay_schedule_controller #(
        .NUM_ENTRIES     (NUM_ENTRIES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_now_ms        (i_now_ms),
        .i_entry_index   (i_entry_index),
        .i_entry_time_ms (i_entry_time_ms),
        .i_entry_level   (i_entry_level),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_relay_level   (o_relay_level),
        .o_heartbeat_led (o_heartbeat_led),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    relay_schedule_checker #(
        .NUM_ENTRIES     (NUM_ENTRIES)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_kind          (i_kind),
        .i_now_ms        (i_now_ms),
        .i_entry_index   (i_entry_index),
        .i_entry_time_ms (i_entry_time_ms),
        .i_entry_level   (i_entry_level),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_relay_level   (o_relay_level),
        .i_heartbeat_led (o_heartbeat_led),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Present one transaction and hold it until the block takes it. An idle
    // burst may come first; valid is then dropped for the whole burst.
    task automatic send_item(input logic kind, input logic [TIME_W-1:0] now,
                             input logic [INDEX_W-1:0] idx,
                             input logic [TIME_W-1:0] etime, input logic elevel);
        if (in_idle_en && !quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_now_ms        <= now;
        i_entry_index   <= idx;
        i_entry_time_ms <= etime;
        i_entry_level   <= elevel;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (kind == KIND_LOAD) begin
            slot_time[idx] = etime;
        end
        items_sent++;
        if (items_sent >= QUIET_FROM) begin
            quiet = 1'b1;
        end
    endtask

    // Fill the unused fields with junk so that every payload bit toggles.
    task automatic send_tick(input logic [TIME_W-1:0] now);
        send_item(KIND_TICK, now, INDEX_W'($urandom), TIME_W'($urandom),
                  1'($urandom));
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx,
                             input logic [TIME_W-1:0] etime, input logic elevel);
        send_item(KIND_LOAD, TIME_W'($urandom), idx, etime, elevel);
    endtask

    // Drop valid, wait for every result, then let a load or a tick in flight
    // run out before registers change.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Write every register; narrow ones carry random upper bits that the
    // block must drop. Now and then hit an index that maps to nothing.
    task automatic configure(input t_mode mode, input logic [TIME_W-1:0] on_ms,
                             input logic [TIME_W-1:0] off_ms, input logic manual,
                             input logic [COUNT_W-1:0] count);
        settle();
        write_reg(CFG_MODE, (CFG_DATA_W'($urandom) << MODE_W) | CFG_DATA_W'(mode));
        write_reg(CFG_ON, on_ms);
        write_reg(CFG_OFF, off_ms);
        write_reg(CFG_MANUAL, (CFG_DATA_W'($urandom) << 1) | CFG_DATA_W'(manual));
        write_reg(CFG_COUNT, (CFG_DATA_W'($urandom) << COUNT_W) | CFG_DATA_W'(count));
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_COUNT + 1, 2**CFG_IDX_W - 1)),
                      CFG_DATA_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // Load a well-formed timeline: ascending times in slots 0 up.
    task automatic load_timeline(input int unsigned used);
        logic [TIME_W-1:0] times [$];
        int unsigned       k;
        repeat (used) times.push_back(TIME_W'($urandom_range(0, DAY_MS - 1)));
        times.sort();
        for (k = 0; k < used; k++) begin
            send_load(INDEX_W'(k), times[k], 1'($urandom));
        end
    endtask

    function automatic logic [TIME_W-1:0] pick_duration();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(1, 5000));
        endcase
    endfunction

    // Pick a time of day: day edges, out-of-day values, and points right at
    // a switch time or a pwm edge, where off-by-one mistakes show.
    function automatic logic [TIME_W-1:0] pick_now(input t_mode mode,
                                                   input int unsigned used,
                                                   input logic [TIME_W-1:0] on_ms,
                                                   input logic [TIME_W-1:0] off_ms);
        int unsigned sel;
        longint      point;
        sel = $urandom_range(0, 15);
        if (sel == 0) return TIME_W'($urandom);
        if (sel == 1) return '0;
        if (sel == 2) return TIME_W'(DAY_MS - 1);
        if (sel == 3) return TIME_MAX;
        if (sel <= 9 && mode == MODE_TIME && used > 0) begin
            point = longint'(slot_time[$urandom_range(0, used - 1)])
                    + $urandom_range(0, 2) - 1;
            return TIME_W'(point);
        end
        if (sel <= 9 && mode == MODE_PWM && on_ms != '0 && off_ms != '0) begin
            point = longint'($urandom_range(0, 20)) * (longint'(on_ms) + longint'(off_ms))
                    + longint'(on_ms) + $urandom_range(0, 2) - 1;
            return TIME_W'(point);
        end
        return TIME_W'($urandom_range(0, DAY_MS - 1));
    endfunction

    // One random phase: new settings, a fresh timeline most of the time in
    // time mode, then ticks mixed with a few stray loads.
    task automatic run_phase();
        t_mode             mode;
        logic [TIME_W-1:0] on_ms;
        logic [TIME_W-1:0] off_ms;
        logic [COUNT_W-1:0] count;
        int unsigned       sel;
        int unsigned       used;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            mode = MODE_OFF;
        end else if (sel == 1) begin
            mode = MODE_MANUAL;
        end else if (sel <= 6) begin
            mode = MODE_TIME;
        end else begin
            mode = MODE_PWM;
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            count = '0;
        end else if (sel == 1) begin
            count = COUNT_W'($urandom_range(NUM_ENTRIES + 1, 2**COUNT_W - 1));
        end else begin
            count = COUNT_W'($urandom_range(1, NUM_ENTRIES));
        end
        used   = (count > NUM_ENTRIES) ? NUM_ENTRIES : count;
        on_ms  = pick_duration();
        off_ms = pick_duration();
        configure(mode, on_ms, off_ms, 1'($urandom), count);
        in_idle_en  = ($urandom_range(0, 2) != 0);
        out_idle_en = ($urandom_range(0, 2) != 0);
        if (mode == MODE_TIME && $urandom_range(0, 3) != 0) begin
            load_timeline(used);
        end
        repeat ($urandom_range(10, 60)) begin
            if ($urandom_range(0, 15) == 0) begin
                send_load(INDEX_W'($urandom), TIME_W'($urandom), 1'($urandom));
            end else begin
                send_tick(pick_now(mode, used, on_ms, off_ms));
            end
        end
    endtask

    // Back-pressure on the result side in random bursts.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_idle_en && !quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // End the run when neither channel nor the register port moves for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int k;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_kind          <= KIND_TICK;
        i_now_ms        <= '0;
        i_entry_index   <= '0;
        i_entry_time_ms <= '0;
        i_entry_level   <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_MODE;
        i_cfg_data      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: off mode, the first tick shows the heartbeat set.
        send_tick('0);

        // Fill every slot before any count can reach it: slot 0 at midnight,
        // the last slot at the final millisecond of the day.
        for (k = 0; k < NUM_ENTRIES; k++) begin
            send_load(INDEX_W'(k),
                      (k == NUM_ENTRIES - 1) ? TIME_W'(DAY_MS - 1) : TIME_W'(k * 5_700_000),
                      (k % 2) == 0);
        end

        configure(MODE_MANUAL, '0, '0, 1'b1, '0);
        send_tick(TIME_MAX);
        configure(MODE_MANUAL, '0, '0, 1'b0, '0);
        send_tick('0);

        // Time mode: empty timeline, single entry, full timeline, count too large.
        configure(MODE_TIME, '0, '0, 1'b0, COUNT_W'(0));
        send_tick(TIME_W'(1000));
        configure(MODE_TIME, '0, '0, 1'b0, COUNT_W'(1));
        send_tick('0);
        send_tick(TIME_W'(50_000_000));
        configure(MODE_TIME, '0, '0, 1'b0, COUNT_W'(NUM_ENTRIES));
        send_tick(slot_time[5]);
        send_tick(slot_time[5] + 1'b1);
        send_tick('0);
        send_tick(TIME_MAX);
        configure(MODE_TIME, '0, '0, 1'b0, '1);
        send_tick(TIME_W'(DAY_MS - 1));

        // Pwm: either duration zero, the edge at on, wrap to a new period, widest.
        configure(MODE_PWM, '0, TIME_W'(1000), 1'b0, '0);
        send_tick(TIME_W'(500));
        configure(MODE_PWM, TIME_W'(1000), '0, 1'b0, '0);
        send_tick(TIME_W'(500));
        configure(MODE_PWM, TIME_W'(1000), TIME_W'(2000), 1'b0, '0);
        send_tick(TIME_W'(1000));
        send_tick(TIME_W'(1001));
        send_tick(TIME_W'(3000));
        configure(MODE_PWM, TIME_MAX, TIME_MAX, 1'b0, '0);
        send_tick(TIME_MAX);

        while (items_sent < ITEM_TARGET) begin
            run_phase();
        end

        settle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/rsc_pkg.sv
rtl/rsc_mod.sv
rtl/rsc_dpath.sv
rtl/rsc_ctrl.sv
rtl/relay_schedule_controller.sv
tb/relay_schedule_tb_pkg.sv
tb/relay_schedule_checker.sv
tb/tb_relay_schedule_controller.sv
